// ===== sv/mwmu_pkg.sv =====
// Package for the maze wall map update block: widths, codes, controller
// states, command/status structs and wall word helpers. No dependencies.
`default_nettype none

package mwmu_pkg;

  // Default maze side and fixed field widths
  localparam int MAZE_SIDE_DEF = 16;
  localparam int COORD_W       = 4;
  localparam int CODE_W        = 2;
  localparam int DIR_W         = 2;
  localparam int WORD_W        = 4 * CODE_W;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 8;
  localparam int SLOT_W        = 2;

  // Wall codes
  localparam logic [CODE_W-1:0] WALL_UNKNOWN = 2'd0;
  localparam logic [CODE_W-1:0] WALL_OPEN    = 2'd1;
  localparam logic [CODE_W-1:0] WALL_CLOSED  = 2'd2;

  // Compass directions
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

  // Item kinds
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Cells visited for one item: own cell, then the three neighbours
  localparam logic [SLOT_W-1:0] SLOT_SELF  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_FRONT = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic              clr_en;
    logic              load_item;
    logic              issue;
    logic [SLOT_W-1:0] slot;
    logic              load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
  } dp_status_t;

  // Code 3 means nothing and is stored as unknown
  function automatic logic [CODE_W-1:0] clean_code(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = (c > WALL_CLOSED) ? WALL_UNKNOWN : c;
    return r;
  endfunction

  // Replace one compass field of a wall word
  function automatic logic [WORD_W-1:0] set_field(input logic [WORD_W-1:0] w,
                                                   input logic [DIR_W-1:0]  d,
                                                   input logic [CODE_W-1:0] c);
    logic [WORD_W-1:0] r;
    r = w;
    r[{d, 1'b0} +: CODE_W] = c;
    return r;
  endfunction

  // Compass direction that a slot deals with, seen from the robot cell
  function automatic logic [DIR_W-1:0] slot_dir(input logic [DIR_W-1:0]  head,
                                                input logic [SLOT_W-1:0] slot);
    logic [DIR_W-1:0] r;
    unique case (slot)
      SLOT_RIGHT: r = head + 2'd1;
      SLOT_LEFT:  r = head + 2'd3;
      default:    r = head;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/maze_wall_map_update.sv =====
// Top level of the maze wall map update block: unpacks the stream beats and
// joins controller and datapath. Depends on mwmu_pkg, mwmu_ctrl, mwmu_datapath.
//
// Usage: each input beat is a record (tuser 0) that writes the sensed front,
// left and right walls of a cell (side walls only off mid-cell), turned to
// compass walls by the heading and mirrored into inside neighbours, or a
// read (tuser 1). Every beat gives one output beat with the four wall codes
// of its cell after the update, all zero when the cell lies outside the maze.
// Timing: an item walks four cell slots (own cell, front, right, left), one
// slot issued per cycle, each write in the cycle after its read on the
// single write port. The result is loaded into the output register from the
// done state, and the next input is taken only after that, back in idle.
// Reset: the wall map is swept to unknown one cell per cycle, all MAZE_SIDE^2
// cells, with s_axis_tready_o low throughout.
// Stall: a waiting result is held in the output register; the next item is
// taken and worked on, and its result waits until the register is free.
`default_nettype none

module maze_wall_map_update #(
  parameter int MAZE_SIDE = mwmu_pkg::MAZE_SIDE_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // cell_x[3:0], cell_y[7:4], heading[9:8], at_mid_cell[10],
  // wall_front[12:11], wall_left[14:13], wall_right[16:15], zero fill
  input  wire [mwmu_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action[0]
  input  wire                                s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // north_wall[1:0], east_wall[3:2], south_wall[5:4], west_wall[7:6]
  output logic [mwmu_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import mwmu_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [WORD_W-1:0] walls;

  mwmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mwmu_datapath #(
    .MAZE_SIDE (MAZE_SIDE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (s_axis_tuser_i),
    .cell_x_i      (s_axis_tdata_i[3:0]),
    .cell_y_i      (s_axis_tdata_i[7:4]),
    .heading_i     (s_axis_tdata_i[9:8]),
    .at_mid_cell_i (s_axis_tdata_i[10]),
    .wall_front_i  (s_axis_tdata_i[12:11]),
    .wall_left_i   (s_axis_tdata_i[14:13]),
    .wall_right_i  (s_axis_tdata_i[16:15]),
    .walls_o       (walls)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(walls);

endmodule

`default_nettype wire

// ===== sv/mwmu_ctrl.sv =====
// Controller for the maze wall map update: clearing pass, slot walk and
// output handshake. Depends on mwmu_pkg.
`default_nettype none

module mwmu_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  mwmu_pkg::dp_status_t status_i,
  output mwmu_pkg::ctrl_cmd_t  cmd_o
);
  import mwmu_pkg::*;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      slot_q      <= SLOT_SELF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_WALK;
      ST_WALK:  if (slot_q == SLOT_LEFT) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    slot_d         = slot_q;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        slot_d          = SLOT_SELF;
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        cmd_o.slot  = slot_q;
        slot_d      = slot_q + 2'd1;
      end
      ST_DRAIN: ;
      ST_DONE:  cmd_o.load_out = out_free;
      default: ;
    endcase
  end

  // Result beat stays until taken
  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/mwmu_datapath.sv =====
// Datapath for the maze wall map update: item registers, wall map memory
// with read-modify-write stage, and result registers. Depends on mwmu_pkg.
`default_nettype none

module mwmu_datapath #(
  parameter int MAZE_SIDE = mwmu_pkg::MAZE_SIDE_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  mwmu_pkg::ctrl_cmd_t                cmd_i,
  output mwmu_pkg::dp_status_t               status_o,
  input  wire                                action_i,
  input  wire [mwmu_pkg::COORD_W-1:0]        cell_x_i,
  input  wire [mwmu_pkg::COORD_W-1:0]        cell_y_i,
  input  wire [mwmu_pkg::DIR_W-1:0]          heading_i,
  input  wire                                at_mid_cell_i,
  input  wire [mwmu_pkg::CODE_W-1:0]         wall_front_i,
  input  wire [mwmu_pkg::CODE_W-1:0]         wall_left_i,
  input  wire [mwmu_pkg::CODE_W-1:0]         wall_right_i,
  output logic [mwmu_pkg::WORD_W-1:0]        walls_o
);
  import mwmu_pkg::*;

  localparam int DEPTH  = MAZE_SIDE * MAZE_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAZE_SIDE);

  // Item registers
  logic               record_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [DIR_W-1:0]   head_q;
  logic               mid_q;
  logic [CODE_W-1:0]  front_q, left_q, right_q;
  logic               inside_q;
  logic [ADDR_W-1:0]  self_addr_q;

  // Memory and write stage
  logic [WORD_W-1:0]  mem_q [DEPTH];
  logic [WORD_W-1:0]  rd_data_q;
  logic               wr_valid_q;
  logic               wr_wen_q;
  logic [SLOT_W-1:0]  wr_slot_q;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic [ADDR_W-1:0]  clr_cnt_q;
  logic [WORD_W-1:0]  res_q;
  logic [WORD_W-1:0]  out_q;

  logic [DIR_W-1:0]   iss_dir;
  logic               nb_ok;
  logic [ADDR_W-1:0]  nb_addr;
  logic               slot_en;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CODE_W-1:0]  wr_code;
  logic [WORD_W-1:0]  self_word;
  logic [WORD_W-1:0]  mod_word;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;

  // Latch the item; the cell address is a constant multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      record_q    <= (action_i == ACT_RECORD);
      x_q         <= cell_x_i;
      y_q         <= cell_y_i;
      head_q      <= heading_i;
      mid_q       <= at_mid_cell_i;
      front_q     <= clean_code(wall_front_i);
      left_q      <= clean_code(wall_left_i);
      right_q     <= clean_code(wall_right_i);
      inside_q    <= (int'(cell_x_i) < MAZE_SIDE) && (int'(cell_y_i) < MAZE_SIDE);
      self_addr_q <= ADDR_W'(int'(cell_y_i) * MAZE_SIDE + int'(cell_x_i));
    end
  end

  // Neighbour of the slot being issued
  assign iss_dir = slot_dir(head_q, cmd_i.slot);

  always_comb begin
    unique case (iss_dir)
      DIR_NORTH: begin
        nb_ok   = (y_q != '0);
        nb_addr = self_addr_q - ROW_STEP;
      end
      DIR_EAST: begin
        nb_ok   = (int'(x_q) < MAZE_SIDE - 1);
        nb_addr = self_addr_q + ADDR_W'(1);
      end
      DIR_SOUTH: begin
        nb_ok   = (int'(y_q) < MAZE_SIDE - 1);
        nb_addr = self_addr_q + ROW_STEP;
      end
      default: begin
        nb_ok   = (x_q != '0);
        nb_addr = self_addr_q - ADDR_W'(1);
      end
    endcase
  end

  // Own cell always read when inside; a neighbour only for a record with a
  // wall to mirror, side walls only off mid-cell
  always_comb begin
    if (cmd_i.slot == SLOT_SELF) begin
      slot_en = inside_q;
      rd_addr = self_addr_q;
    end else begin
      slot_en = inside_q && record_q && nb_ok &&
                ((cmd_i.slot == SLOT_FRONT) || !mid_q);
      rd_addr = nb_addr;
    end
  end

  assign rd_en = cmd_i.issue && slot_en;

  // Write stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      wr_valid_q <= rd_en;
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_wen_q  <= record_q;
    wr_slot_q <= cmd_i.slot;
    wr_addr_q <= rd_addr;
  end

  assign status_o.clr_last = (clr_cnt_q == ADDR_LAST);

  // Modify the word read last cycle
  always_comb begin
    unique case (wr_slot_q)
      SLOT_RIGHT: wr_code = right_q;
      SLOT_LEFT:  wr_code = left_q;
      default:    wr_code = front_q;
    endcase
  end

  always_comb begin
    self_word = set_field(rd_data_q, head_q, front_q);
    if (!mid_q) begin
      self_word = set_field(self_word, head_q + 2'd1, right_q);
      self_word = set_field(self_word, head_q + 2'd3, left_q);
    end
    if (wr_slot_q == SLOT_SELF) begin
      mod_word = self_word;
    end else begin
      mod_word = set_field(rd_data_q, slot_dir(head_q, wr_slot_q) + 2'd2, wr_code);
    end
  end

  // Memory write port is shared by the clearing pass and the update
  assign mem_we    = cmd_i.clr_en | (wr_valid_q & wr_wen_q);
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : wr_addr_q;
  assign mem_wdata = cmd_i.clr_en ? '0 : mod_word;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Result: own cell after the step, zero for a cell outside the maze
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      res_q <= '0;
    end else if (wr_valid_q && (wr_slot_q == SLOT_SELF)) begin
      res_q <= wr_wen_q ? mod_word : rd_data_q;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign walls_o = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/maze_wall_map_checker.sv =====
// Checker for maze_wall_map_update: watches both stream channels, keeps its own
// copy of the wall map, predicts each result beat and compares it field by field.
// Depends on mwmu_pkg only.

module maze_wall_map_checker
  import mwmu_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid_i,
  input  wire                  s_axis_tready_i,
  // cell_x[3:0], cell_y[7:4], heading[9:8], at_mid_cell[10],
  // wall_front[12:11], wall_left[14:13], wall_right[16:15], zero fill
  input  wire [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  wire                  s_axis_tuser_i,
  input  wire                  m_axis_tvalid_i,
  input  wire                  m_axis_tready_i,
  // north_wall[1:0], east_wall[3:2], south_wall[5:4], west_wall[7:6]
  input  wire [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE      = MAZE_SIDE_DEF;
  localparam int MAX_SHOWN = 10;

  // Our copy of the map, one wall word per cell
  logic [WORD_W-1:0]     wall_word [SIDE*SIDE];
  // Wall words still owed by the block, oldest first
  logic [OUT_DATA_W-1:0] walls_due [$];
  int                    fails;
  int                    results_seen;

  initial begin
    fails        = 0;
    results_seen = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Overwrite one compass code of a cell that is known to be inside
  function automatic void store_code(input int x, input int y,
                                     input logic [DIR_W-1:0] dir,
                                     input logic [CODE_W-1:0] code);
    wall_word[y*SIDE + x][dir*CODE_W +: CODE_W] = code;
  endfunction

  // Own wall plus the shared wall of the neighbour, when the neighbour exists
  function automatic void sense_wall(input int x, input int y,
                                     input logic [DIR_W-1:0] dir,
                                     input logic [CODE_W-1:0] raw);
    logic [CODE_W-1:0] code;
    code = (raw > WALL_CLOSED) ? WALL_UNKNOWN : raw;
    store_code(x, y, dir, code);
    case (dir)
      DIR_NORTH: if (y > 0)        store_code(x, y - 1, DIR_SOUTH, code);
      DIR_EAST:  if (x < SIDE - 1) store_code(x + 1, y, DIR_WEST, code);
      DIR_SOUTH: if (y < SIDE - 1) store_code(x, y + 1, DIR_NORTH, code);
      default:   if (x > 0)        store_code(x - 1, y, DIR_EAST, code);
    endcase
  endfunction

  // Apply one input beat to the map and give the wall word it should return
  function automatic logic [OUT_DATA_W-1:0] update_cell(input logic act,
                                                       input logic [IN_DATA_W-1:0] beat);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DIR_W-1:0]   head;
    logic [DIR_W-1:0]   dir_r;
    logic [DIR_W-1:0]   dir_l;
    logic               mid;
    logic [CODE_W-1:0]  front;
    logic [CODE_W-1:0]  left;
    logic [CODE_W-1:0]  right;
    x     = beat[3:0];
    y     = beat[7:4];
    head  = beat[9:8];
    mid   = beat[10];
    front = beat[12:11];
    left  = beat[14:13];
    right = beat[16:15];
    if (x >= SIDE || y >= SIDE) return '0;
    if (act == ACT_RECORD) begin
      dir_r = head + 2'd1;
      dir_l = head - 2'd1;
      // side walls only while passing the cell boundary
      if (!mid) begin
        sense_wall(x, y, dir_r, right);
        sense_wall(x, y, dir_l, left);
      end
      sense_wall(x, y, head, front);
    end
    return wall_word[y*SIDE + x];
  endfunction

  // Compare each output beat first, then log the prediction for an input beat
  always @(posedge clk_i) begin : watch
    logic [OUT_DATA_W-1:0] want;
    logic [OUT_DATA_W-1:0] got;
    bit                    bad;
    if (!rst_ni) begin
      for (int i = 0; i < SIDE*SIDE; i++) wall_word[i] = '0;
      walls_due.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (walls_due.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("%0t: result beat %0d with nothing expected, data %h",
                     $realtime, results_seen, got);
        end else begin
          want = walls_due.pop_front();
          bad  = 1'b0;
          for (int f = 0; f < 4; f++)
            if (got[f*CODE_W +: CODE_W] !== want[f*CODE_W +: CODE_W]) bad = 1'b1;
          if (bad) begin
            fails++;
            if (fails <= MAX_SHOWN)
              $display("%0t: walls of result %0d: expected N%0d E%0d S%0d W%0d,",
                       $realtime, results_seen,
                       want[1:0], want[3:2], want[5:4], want[7:6],
                       " got N%0d E%0d S%0d W%0d",
                       got[1:0], got[3:2], got[5:4], got[7:6]);
          end
        end
        results_seen++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        walls_due.push_back(update_cell(s_axis_tuser_i, s_axis_tdata_i));
    end
    fail_count_o <= fails;
    pending_o    <= walls_due.size();
  end

endmodule

// ===== tb/sv/tb_maze_wall_map_update.sv =====
// Testbench top for maze_wall_map_update: clock, reset, beat stimulus with
// random gaps and back-pressure, watchdog and verdict.
// Depends on mwmu_pkg, maze_wall_map_update and maze_wall_map_checker.

module tb_maze_wall_map_update;

  timeunit 1ns;
  timeprecision 1ps;

  import mwmu_pkg::*;

  localparam int N_RANDOM    = 1530;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 20;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CODE_W-1:0] CODE_SPARE = 2'd3;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = ACT_READ;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int items_sent   = 0;
  bit hold_done    = 1'b0;
  bit steady_send  = 1'b0;

  maze_wall_map_update dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  maze_wall_map_checker map_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (mismatches),
    .pending_o       (outstanding)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favour edges and corner clusters so mirrors overlap and get dropped often
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return COORD_W'($urandom_range(0, 15));
    if (r < 7) return $urandom_range(0, 1) ? 4'd15 : 4'd0;
    return $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 2))
                                : COORD_W'($urandom_range(13, 15));
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return WALL_OPEN;
    if (r < 85) return WALL_CLOSED;
    if (r < 93) return WALL_UNKNOWN;
    return CODE_SPARE;
  endfunction

  // Offer one beat, hold it until taken, then maybe drop valid for a while
  task automatic send_beat(input logic act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [DIR_W-1:0] head,
                           input logic mid, input logic [CODE_W-1:0] front,
                           input logic [CODE_W-1:0] left, input logic [CODE_W-1:0] right);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W-17){1'b0}}, right, left, front, mid, head, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    gap = pick_gap(steady_send);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random ready pattern with one long hold-off mid-run
  initial begin : sink
    int burst;
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      repeat (burst) @(posedge clk_i);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stim
    int r;
    wait (rst_ni);
    @(posedge clk_i);

    // untouched cells read back unknown
    send_beat(ACT_READ,   4'd0,  4'd0,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    send_beat(ACT_READ,   4'd15, 4'd15, DIR_WEST,  1'b1, CODE_SPARE, CODE_SPARE, CODE_SPARE);
    // corners: mirrors that leave the maze are dropped
    send_beat(ACT_RECORD, 4'd0,  4'd0,  DIR_NORTH, 1'b0, WALL_CLOSED, WALL_CLOSED, WALL_OPEN);
    send_beat(ACT_READ,   4'd1,  4'd0,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    // heading south on the last row: no south neighbour
    send_beat(ACT_RECORD, 4'd15, 4'd15, DIR_SOUTH, 1'b0, WALL_CLOSED, WALL_OPEN, WALL_CLOSED);
    send_beat(ACT_READ,   4'd14, 4'd15, DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    send_beat(ACT_RECORD, 4'd15, 4'd0,  DIR_EAST,  1'b0, WALL_CLOSED, WALL_CLOSED, WALL_OPEN);
    send_beat(ACT_READ,   4'd15, 4'd1,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    send_beat(ACT_RECORD, 4'd0,  4'd15, DIR_WEST,  1'b0, WALL_CLOSED, WALL_CLOSED, WALL_OPEN);
    send_beat(ACT_READ,   4'd0,  4'd14, DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    // mid-cell: only the front wall goes in
    send_beat(ACT_RECORD, 4'd7,  4'd8,  DIR_NORTH, 1'b1, WALL_OPEN, WALL_CLOSED, WALL_CLOSED);
    send_beat(ACT_READ,   4'd6,  4'd8,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    send_beat(ACT_RECORD, 4'd7,  4'd7,  DIR_SOUTH, 1'b1, WALL_CLOSED, WALL_OPEN, WALL_OPEN);
    send_beat(ACT_READ,   4'd7,  4'd8,  DIR_EAST,  1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    // spare code overwrites known walls with unknown
    send_beat(ACT_RECORD, 4'd3,  4'd3,  DIR_EAST,  1'b0, WALL_CLOSED, WALL_CLOSED, WALL_CLOSED);
    send_beat(ACT_RECORD, 4'd3,  4'd3,  DIR_WEST,  1'b0, CODE_SPARE, CODE_SPARE, CODE_SPARE);
    send_beat(ACT_READ,   4'd4,  4'd3,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);
    send_beat(ACT_RECORD, 4'd5,  4'd5,  DIR_WEST,  1'b0, WALL_UNKNOWN, WALL_OPEN, WALL_CLOSED);
    send_beat(ACT_RECORD, 4'd10, 4'd2,  DIR_SOUTH, 1'b0, WALL_OPEN, WALL_CLOSED, WALL_UNKNOWN);
    send_beat(ACT_READ,   4'd10, 4'd3,  DIR_NORTH, 1'b0, WALL_UNKNOWN, WALL_UNKNOWN, WALL_UNKNOWN);

    // random part: mostly well-formed records, read-backs and some noise
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) steady_send = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 60)
        send_beat(ACT_RECORD, pick_coord(), pick_coord(), DIR_W'($urandom_range(0, 3)),
                  $urandom_range(0, 3) == 0, pick_code(), pick_code(), pick_code());
      else if (r < 90)
        send_beat(ACT_READ, pick_coord(), pick_coord(), DIR_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 3)),
                  CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)));
      else
        send_beat(1'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 15)),
                  COORD_W'($urandom_range(0, 15)), DIR_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 3)),
                  CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)));
    end
    s_axis_tvalid <= 1'b0;

    // let the last results drain out
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (mismatches == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mwmu_pkg.sv
sv/mwmu_ctrl.sv
sv/mwmu_datapath.sv
sv/maze_wall_map_update.sv
tb/sv/maze_wall_map_checker.sv
tb/sv/tb_maze_wall_map_update.sv
